@@ sv/indexed_insert_remove_list_core_defines.svh @@
// assertion macros for the list core
`ifndef INDEXED_INSERT_REMOVE_LIST_CORE_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_CORE_DEFINES_SVH

// antecedent holds, consequent in the same cycle
`define IIRL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iirl: same-cycle property failed");

// antecedent holds, consequent in the next cycle
`define IIRL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iirl: next-cycle property failed");

`endif

@@ sv/iirl_pkg.sv @@
package iirl_pkg;

   localparam logic [2:0] OP_INSERT      = 3'd0;
   localparam logic [2:0] OP_APPEND      = 3'd1;
   localparam logic [2:0] OP_REMOVE      = 3'd2;
   localparam logic [2:0] OP_REMOVE_LAST = 3'd3;
   localparam logic [2:0] OP_SEARCH      = 3'd4;
   localparam logic [2:0] OP_READ        = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_INS_RD,
      S_INS_WR,
      S_PUT,
      S_REM_RD,
      S_REM_WR,
      S_DROP,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_RD_RD,
      S_RD_GET,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      IX_HOLD,
      IX_COUNT,
      IX_POS,
      IX_ZERO,
      IX_INC,
      IX_DEC
   } idx_sel_type;

   typedef enum logic [1:0] {
      RA_IDX,
      RA_DEC,
      RA_INC
   } raddr_sel_type;

   typedef struct packed {
      logic          load;
      logic          take_status;
      idx_sel_type   idx_sel;
      raddr_sel_type raddr_sel;
      logic          ram_wr;
      logic          wr_val;
      logic          cnt_inc;
      logic          cnt_dec;
      logic          set_found;
      logic          take_read;
      logic          finish;
   } cmd_type;

   typedef struct packed {
      logic ins_go;
      logic app_go;
      logic rem_go;
      logic rml_go;
      logic srch_go;
      logic rd_go;
      logic ins_shift;
      logic rem_shift;
      logic ins_more;
      logic rem_more;
      logic srch_more;
      logic cnt_zero;
      logic hit;
      logic out_busy;
   } sts_type;

endpackage

@@ sv/indexed_insert_remove_list_core.sv @@
// one item at a time: the controller accepts a request only in idle, and a finished
// item waits in its finish state while an earlier result is still not taken
// shifts walk the entry ram one entry at a time, with a read state and a write state;
// a search reads and then compares one entry at a time
// reset: synchronous, clears the count, the controller and the result valid;
// entry contents are left as they are
`include "indexed_insert_remove_list_core_defines.svh"

module indexed_insert_remove_list_core
   import iirl_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // position[8:0], value[40:9], zero fill
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // read_value[31:0], count[40:32], zero fill
   output logic [2:0]  rsp_tuser    // status[1:0], found[2]
);

   localparam logic [8:0] DEPTH_LO = 9'(DEPTH);

   cmd_type            cmd;
   sts_type            sts;
   logic [1:0]         rsp_status;
   logic               rsp_found;
   logic signed [31:0] rsp_read_value;
   logic [8:0]         rsp_count;

   iirl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   iirl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_opcode     (req_tuser),
      .req_position   (req_tdata[8:0]),
      .req_value      (req_tdata[40:9]),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   assign rsp_tdata = {7'd0, rsp_count, rsp_read_value};
   assign rsp_tuser = {rsp_found, rsp_status};

   `IIRL_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   `IIRL_ASSERT_SAME(a_full_count, clock, reset, rsp_tvalid && rsp_status == ST_FULL, rsp_count == DEPTH_LO)
   `IIRL_ASSERT_SAME(a_empty_count, clock, reset, rsp_tvalid && rsp_status == ST_EMPTY, rsp_count == 9'd0)

endmodule

@@ sv/iirl_ram.sv @@
module iirl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ sv/iirl_datapath.sv @@
module iirl_datapath
   import iirl_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_opcode,
   input  logic [8:0]         req_position,
   input  logic signed [31:0] req_value,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic signed [31:0] rsp_read_value,
   output logic [8:0]         rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > 9) ? CW : 9) + 1;
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

   logic [2:0]         op_ff;
   logic [8:0]         pos_ff;
   logic signed [31:0] val_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [1:0]         status_ff;
   logic               found_ff;
   logic signed [31:0] rdval_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_found_ff;
   logic signed [31:0] rsp_rdval_ff;
   logic [8:0]         rsp_count_ff;

   logic [XW-1:0]      count_x, pos_x, idx_x;
   logic [1:0]         code;
   logic               full, empty;
   logic [AW-1:0]      raddr;
   logic [31:0]        rdata;
   logic [31:0]        wdata;

   assign count_x = XW'(count_ff);
   assign pos_x   = XW'(pos_ff);
   assign idx_x   = XW'(idx_ff);
   assign full    = count_x >= DEPTH_X;
   assign empty   = count_x == '0;

   always_comb begin
      unique case (op_ff)
         OP_INSERT:      code = (pos_x > count_x) ? ST_BAD : (full ? ST_FULL : ST_OK);
         OP_APPEND:      code = full ? ST_FULL : ST_OK;
         OP_REMOVE:      code = empty ? ST_EMPTY : ((pos_x >= count_x) ? ST_BAD : ST_OK);
         OP_REMOVE_LAST: code = empty ? ST_EMPTY : ST_OK;
         OP_READ:        code = (pos_x >= count_x) ? ST_BAD : ST_OK;
         default:        code = ST_OK;
      endcase
   end

   always_comb begin
      sts.ins_go    = (op_ff == OP_INSERT) && (code == ST_OK);
      sts.app_go    = (op_ff == OP_APPEND) && (code == ST_OK);
      sts.rem_go    = (op_ff == OP_REMOVE) && (code == ST_OK);
      sts.rml_go    = (op_ff == OP_REMOVE_LAST) && (code == ST_OK);
      sts.srch_go   = op_ff == OP_SEARCH;
      sts.rd_go     = (op_ff == OP_READ) && (code == ST_OK);
      sts.ins_shift = count_x > pos_x;
      sts.rem_shift = (pos_x + XW'(1)) < count_x;
      sts.ins_more  = idx_x > (pos_x + XW'(1));
      sts.rem_more  = (idx_x + XW'(2)) < count_x;
      sts.srch_more = (idx_x + XW'(1)) < count_x;
      sts.cnt_zero  = empty;
      sts.hit       = rdata == val_ff;
      sts.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      unique case (cmd.raddr_sel)
         RA_IDX:  raddr = idx_ff;
         RA_DEC:  raddr = idx_ff - AW'(1);
         RA_INC:  raddr = idx_ff + AW'(1);
         default: raddr = idx_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.idx_sel)
         IX_HOLD:  idx_in = idx_ff;
         IX_COUNT: idx_in = AW'(count_ff);
         IX_POS:   idx_in = AW'(pos_x);
         IX_ZERO:  idx_in = '0;
         IX_INC:   idx_in = idx_ff + AW'(1);
         IX_DEC:   idx_in = idx_ff - AW'(1);
         default:  idx_in = idx_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign wdata = cmd.wr_val ? val_ff : rdata;

   iirl_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.ram_wr),
      .waddr (idx_ff),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         op_ff    <= req_opcode;
         pos_ff   <= req_position;
         val_ff   <= req_value;
         found_ff <= 1'b0;
         rdval_ff <= '0;
      end
      if (cmd.take_status) begin
         status_ff <= code;
      end
      if (cmd.set_found) begin
         found_ff <= 1'b1;
      end
      if (cmd.take_read) begin
         rdval_ff <= rdata;
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_rdval_ff  <= rdval_ff;
         rsp_count_ff  <= 9'(count_ff);
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_rdval_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

@@ sv/iirl_ctrl.sv @@
module iirl_ctrl
   import iirl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (sts.ins_go) begin
               state_in = sts.ins_shift ? S_INS_RD : S_PUT;
            end else if (sts.app_go) begin
               state_in = S_PUT;
            end else if (sts.rem_go) begin
               state_in = sts.rem_shift ? S_REM_RD : S_DROP;
            end else if (sts.rml_go) begin
               state_in = S_DROP;
            end else if (sts.srch_go) begin
               state_in = sts.cnt_zero ? S_FINISH : S_SRCH_RD;
            end else if (sts.rd_go) begin
               state_in = S_RD_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_INS_RD:   state_in = S_INS_WR;
         S_INS_WR:   state_in = sts.ins_more ? S_INS_RD : S_PUT;
         S_PUT:      state_in = S_FINISH;
         S_REM_RD:   state_in = S_REM_WR;
         S_REM_WR:   state_in = sts.rem_more ? S_REM_RD : S_DROP;
         S_DROP:     state_in = S_FINISH;
         S_SRCH_RD:  state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            priority if (sts.hit) begin
               state_in = S_FINISH;
            end else if (sts.srch_more) begin
               state_in = S_SRCH_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_RD_RD:    state_in = S_RD_GET;
         S_RD_GET:   state_in = S_FINISH;
         S_FINISH: begin
            if (!sts.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.idx_sel     = IX_HOLD;
      cmd.raddr_sel   = RA_IDX;
      req_tready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = !reset;
            cmd.load   = req_tvalid && !reset;
         end
         S_DECIDE: begin
            cmd.take_status = 1'b1;
            priority if (sts.ins_go || sts.app_go) begin
               cmd.idx_sel = IX_COUNT;
            end else if (sts.rem_go || sts.rd_go) begin
               cmd.idx_sel = IX_POS;
            end else if (sts.srch_go) begin
               cmd.idx_sel = IX_ZERO;
            end else begin
               cmd.idx_sel = IX_HOLD;
            end
         end
         S_INS_RD: cmd.raddr_sel = RA_DEC;
         S_INS_WR: begin
            cmd.ram_wr  = 1'b1;
            cmd.idx_sel = IX_DEC;
         end
         S_PUT: begin
            cmd.ram_wr  = 1'b1;
            cmd.wr_val  = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         S_REM_RD: cmd.raddr_sel = RA_INC;
         S_REM_WR: begin
            cmd.ram_wr  = 1'b1;
            cmd.idx_sel = IX_INC;
         end
         S_DROP:   cmd.cnt_dec = 1'b1;
         S_SRCH_RD: cmd.raddr_sel = RA_IDX;
         S_SRCH_CMP: begin
            cmd.set_found = sts.hit;
            if (!sts.hit && sts.srch_more) begin
               cmd.idx_sel = IX_INC;
            end
         end
         S_RD_RD:  cmd.raddr_sel = RA_IDX;
         S_RD_GET: cmd.take_read = 1'b1;
         S_FINISH: cmd.finish = !sts.out_busy;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

@@ tb/sv/indexed_insert_remove_list_core_test.sv @@
`timescale 1ns / 1ps

module indexed_insert_remove_list_core_test
   import iirl_pkg::*;
;

   localparam int DEPTH = 256;
   localparam logic [2:0] OP_SPARE0 = 3'd6;
   localparam logic [2:0] OP_SPARE1 = 3'd7;
   localparam int NUM_ROWS = 25;
   localparam int PHASE_ITEMS = 530;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [31:0] read_value;
      logic [8:0]  count;
   } list_result_type;

   typedef struct packed {
      logic [2:0]      op;
      logic [8:0]      pos;
      logic [31:0]     val;
      logic            typed;
      list_result_type res;
   } list_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // position[8:0], value[40:9], zero fill
   logic [2:0]  req_tuser;   // opcode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // read_value[31:0], count[40:32], zero fill
   logic [2:0]  rsp_tuser;   // status[1:0], found[2]

   logic [31:0]     shadow_list [DEPTH];
   int              shadow_len = 0;
   list_result_type awaited_results [$];
   int              fail_count = 0;
   int              items_sent = 0;
   int              send_idle = 0;
   int              recv_idle = 0;

   list_row_type directed_rows [NUM_ROWS] = '{
      '{OP_REMOVE,      9'd0,   32'd0,         1'b1, '{ST_EMPTY, 1'b0, 32'd0, 9'd0}},
      '{OP_REMOVE_LAST, 9'd0,   32'd0,         1'b1, '{ST_EMPTY, 1'b0, 32'd0, 9'd0}},
      '{OP_READ,        9'd0,   32'd0,         1'b1, '{ST_BAD,   1'b0, 32'd0, 9'd0}},
      '{OP_SEARCH,      9'd0,   32'd0,         1'b1, '{ST_OK,    1'b0, 32'd0, 9'd0}},
      '{OP_INSERT,      9'd1,   32'd5,         1'b1, '{ST_BAD,   1'b0, 32'd0, 9'd0}},
      '{OP_INSERT,      9'd0,   32'h7fffffff,  1'b1, '{ST_OK,    1'b0, 32'd0, 9'd1}},
      '{OP_APPEND,      9'd0,   32'h80000000,  1'b1, '{ST_OK,    1'b0, 32'd0, 9'd2}},
      '{OP_INSERT,      9'd2,   32'hffffffff,  1'b1, '{ST_OK,    1'b0, 32'd0, 9'd3}},
      '{OP_INSERT,      9'd1,   32'd0,         1'b0, '0},
      '{OP_READ,        9'd0,   32'd0,         1'b1, '{ST_OK, 1'b0, 32'h7fffffff, 9'd4}},
      '{OP_READ,        9'd3,   32'd0,         1'b1, '{ST_OK, 1'b0, 32'hffffffff, 9'd4}},
      '{OP_READ,        9'd4,   32'd0,         1'b1, '{ST_BAD,   1'b0, 32'd0, 9'd4}},
      '{OP_READ,        9'd511, 32'd0,         1'b1, '{ST_BAD,   1'b0, 32'd0, 9'd4}},
      '{OP_SEARCH,      9'd0,   32'h80000000,  1'b1, '{ST_OK,    1'b1, 32'd0, 9'd4}},
      '{OP_SEARCH,      9'd0,   32'd1,         1'b1, '{ST_OK,    1'b0, 32'd0, 9'd4}},
      '{OP_REMOVE,      9'd4,   32'd0,         1'b1, '{ST_BAD,   1'b0, 32'd0, 9'd4}},
      '{OP_REMOVE,      9'd1,   32'd0,         1'b0, '0},
      '{OP_READ,        9'd1,   32'd0,         1'b1, '{ST_OK, 1'b0, 32'h80000000, 9'd3}},
      '{OP_INSERT,      9'd256, 32'd0,         1'b1, '{ST_BAD,   1'b0, 32'd0, 9'd3}},
      '{OP_SPARE0,      9'd0,   32'd0,         1'b1, '{ST_OK,    1'b0, 32'd0, 9'd3}},
      '{OP_SPARE1,      9'd511, 32'hffffffff,  1'b1, '{ST_OK,    1'b0, 32'd0, 9'd3}},
      '{OP_REMOVE_LAST, 9'd0,   32'd0,         1'b1, '{ST_OK,    1'b0, 32'd0, 9'd2}},
      '{OP_REMOVE,      9'd0,   32'd0,         1'b0, '0},
      '{OP_READ,        9'd0,   32'd0,         1'b1, '{ST_OK, 1'b0, 32'h80000000, 9'd1}},
      '{OP_REMOVE_LAST, 9'd0,   32'd0,         1'b1, '{ST_OK,    1'b0, 32'd0, 9'd0}}
   };

   indexed_insert_remove_list_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic list_result_type predict_list_op(input logic [2:0] op,
                                                       input logic [8:0] pos,
                                                       input logic [31:0] val);
      list_result_type r;
      int p;
      r = '0;
      p = pos;
      case (op)
         OP_INSERT: begin
            if (p > shadow_len) begin
               r.status = ST_BAD;
            end else if (shadow_len >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i - 1];
               shadow_list[p] = val;
               shadow_len++;
            end
         end
         OP_APPEND: begin
            if (shadow_len >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_list[shadow_len] = val;
               shadow_len++;
            end
         end
         OP_REMOVE: begin
            if (shadow_len == 0) begin
               r.status = ST_EMPTY;
            end else if (p >= shadow_len) begin
               r.status = ST_BAD;
            end else begin
               for (int i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
               shadow_len--;
            end
         end
         OP_REMOVE_LAST: begin
            if (shadow_len == 0) r.status = ST_EMPTY;
            else shadow_len--;
         end
         OP_SEARCH: begin
            for (int i = 0; i < shadow_len; i++) begin
               if (shadow_list[i] == val) r.found = 1'b1;
            end
         end
         OP_READ: begin
            if (p >= shadow_len) r.status = ST_BAD;
            else r.read_value = shadow_list[p];
         end
         default: begin
         end
      endcase
      r.count = 9'(shadow_len);
      return r;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'hffffffff;
         2: return 32'h7fffffff;
         3: return 32'h80000000;
         4: return 32'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic push_item(input logic [2:0] op, input logic [8:0] pos,
                            input logic [31:0] val, input logic typed,
                            input list_result_type typed_res);
      list_result_type res;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {7'd0, val, pos};
      do @(posedge clock); while (!req_tready);
      res = predict_list_op(op, pos, val);
      if (typed) res = typed_res;
      awaited_results.push_back(res);
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic random_item(input int cap);
      int roll;
      int p;
      logic [2:0] op;
      logic [31:0] v;
      roll = $urandom_range(99);
      v = pick_value();
      p = 0;
      if (shadow_len >= cap && roll < 36) roll = 36 + $urandom_range(23);
      if (roll < 18) begin
         op = OP_INSERT;
         p = $urandom_range(shadow_len);
      end else if (roll < 36) begin
         op = OP_APPEND;
      end else if (roll < 50) begin
         op = OP_REMOVE;
         p = (shadow_len > 0) ? $urandom_range(shadow_len - 1) : 0;
      end else if (roll < 60) begin
         op = OP_REMOVE_LAST;
      end else if (roll < 76) begin
         op = OP_SEARCH;
         if (shadow_len > 0 && $urandom_range(1) == 1)
            v = shadow_list[$urandom_range(shadow_len - 1)];
      end else if (roll < 95) begin
         op = OP_READ;
         p = (shadow_len > 0) ? $urandom_range(shadow_len - 1) : 0;
      end else begin
         op = ($urandom_range(1) == 1) ? OP_SPARE1 : OP_SPARE0;
      end
      if ($urandom_range(99) < 12) p = $urandom_range(511);
      push_item(op, 9'(p), v, 1'b0, '0);
   endtask

   // fill to capacity, poke the full list, then drain back down
   task automatic fill_and_drain();
      int roll;
      while (shadow_len < DEPTH) begin
         roll = $urandom_range(99);
         if (roll < 60)
            push_item(OP_APPEND, 9'($urandom_range(511)), pick_value(), 1'b0, '0);
         else if (roll < 80 || shadow_len < 3)
            push_item(OP_INSERT, 9'(shadow_len), pick_value(), 1'b0, '0);
         else if (roll < 92)
            push_item(OP_INSERT, 9'(shadow_len - $urandom_range(2)), pick_value(), 1'b0, '0);
         else
            push_item(OP_READ, 9'($urandom_range(shadow_len - 1)), 32'd0, 1'b0, '0);
      end
      push_item(OP_APPEND, 9'd0, pick_value(), 1'b0, '0);
      push_item(OP_INSERT, 9'd0, pick_value(), 1'b0, '0);
      push_item(OP_INSERT, 9'd256, pick_value(), 1'b0, '0);
      push_item(OP_INSERT, 9'd257, pick_value(), 1'b0, '0);
      push_item(OP_READ, 9'd255, 32'd0, 1'b0, '0);
      push_item(OP_READ, 9'd256, 32'd0, 1'b0, '0);
      push_item(OP_SEARCH, 9'd0, shadow_list[DEPTH - 1], 1'b0, '0);
      push_item(OP_SEARCH, 9'd0, $urandom, 1'b0, '0);
      push_item(OP_REMOVE, 9'd256, 32'd0, 1'b0, '0);
      push_item(OP_REMOVE, 9'd255, 32'd0, 1'b0, '0);
      push_item(OP_INSERT, 9'd0, pick_value(), 1'b0, '0);
      push_item(OP_REMOVE, 9'd0, 32'd0, 1'b0, '0);
      while (shadow_len > 8) begin
         if ($urandom_range(99) < 70)
            push_item(OP_REMOVE_LAST, 9'($urandom_range(511)), 32'd0, 1'b0, '0);
         else
            push_item(OP_REMOVE, 9'(shadow_len - 1 - $urandom_range(3)), 32'd0, 1'b0, '0);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result tuser %h tdata %h", $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser[1:0] !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_tuser[1:0]);
               fail_count++;
            end
            if (rsp_tuser[2] !== want.found) begin
               $display("%0t: found expected %0d got %0d", $time, want.found, rsp_tuser[2]);
               fail_count++;
            end
            if (rsp_tdata[31:0] !== want.read_value) begin
               $display("%0t: read_value expected %h got %h", $time, want.read_value,
                        rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[40:32] !== want.count) begin
               $display("%0t: count expected %0d got %0d", $time, want.count,
                        rsp_tdata[40:32]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #30_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int cap;
      int phase_end;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle = 34;
      recv_idle = 52;
      for (int r = 0; r < NUM_ROWS; r++) begin
         push_item(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val,
                   directed_rows[r].typed, directed_rows[r].res);
      end
      cap = 8;
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle = 34; recv_idle = 52; end
            1: begin send_idle = 52; recv_idle = 34; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         phase_end = items_sent + PHASE_ITEMS;
         if (ph == 0) fill_and_drain();
         while (items_sent < phase_end) begin
            if (items_sent % 40 == 0)
               cap = ($urandom_range(9) == 0) ? 96 : $urandom_range(2, 32);
            random_item(cap);
         end
      end
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
